FILE: rtl/csfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csfs_pkg;

    localparam int MAX_MSG_LEN_DEF = 21;
    localparam int BYTE_W          = 8;
    localparam int POS_W           = 5;
    localparam int M_TDATA_W       = 16;
    localparam logic [BYTE_W-1:0] SYNC_MID_RST = 8'd128;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_SYNC,
        MODE_FRAME
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } rd_state_t;

endpackage

`default_nettype wire

FILE: rtl/csfs_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module csfs_buf
    import csfs_pkg::*;
#(
    parameter int DEPTH = MAX_MSG_LEN_DEF,
    parameter int AW    = $clog2(MAX_MSG_LEN_DEF)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [BYTE_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/csfs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module csfs_ctrl
    import csfs_pkg::*;
#(
    parameter int MAX_MSG_LEN = MAX_MSG_LEN_DEF,
    parameter int AW          = $clog2(MAX_MSG_LEN_DEF),
    parameter int CW          = $clog2(MAX_MSG_LEN_DEF + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [BYTE_W-1:0]    cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tuser,
    output logic                      mem_we,
    output logic      [AW-1:0]        mem_waddr,
    output logic      [BYTE_W-1:0]    mem_wdata,
    output logic                      mem_re,
    output logic      [AW-1:0]        mem_raddr,
    input  wire logic [BYTE_W-1:0]    mem_rdata
);

    localparam logic [CW-1:0] MAX_C = CW'(MAX_MSG_LEN);

    logic [BYTE_W-1:0] sync_mid_reg;
    mode_t             mode_reg, mode_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     frame_len_reg, frame_len_next;
    logic              from_sync_reg, from_sync_next;
    rd_state_t         state_reg, state_next;
    logic [AW-1:0]     rd_idx_reg, rd_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic              out_last_reg;
    logic              out_sync_reg;

    logic              accept;
    logic              frame_done;
    logic [CW-1:0]     cnt_inc;
    logic [BYTE_W-1:0] sum_add;
    logic              load;
    logic              rd_last;
    logic [AW+POS_W-1:0] pos_ext;

    assign accept  = s_tvalid && s_tready;
    assign cnt_inc = count_reg + CW'(1);
    assign sum_add = sum_reg + s_tdata;
    assign rd_last = (CW'(rd_idx_reg) + CW'(1)) == frame_len_reg;
    // byte position wraps mod 32 for long frames
    assign pos_ext = {{POS_W{1'b0}}, rd_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_mid_reg <= SYNC_MID_RST;
        end
        else if (cfg_we)
        begin
            sync_mid_reg <= cfg_wdata;
        end
    end

    // framing: mode, running sum, byte count, buffer writes
    always_comb
    begin
        mode_next      = mode_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        frame_len_next = frame_len_reg;
        from_sync_next = from_sync_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = s_tdata;
        frame_done     = 1'b0;
        if (accept)
        begin
            unique case (mode_reg)
                MODE_HUNT:
                begin
                    if (s_tdata == sync_mid_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = '0;
                        count_next = CW'(1);
                        sum_next   = s_tdata;
                        mode_next  = MODE_SYNC;
                    end
                end
                MODE_SYNC, MODE_FRAME:
                begin
                    if (count_reg >= MAX_C)
                    begin
                        mode_next  = MODE_HUNT;
                        sum_next   = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (sum_reg != '0 && sum_add == '0)
                        begin
                            frame_done     = 1'b1;
                            frame_len_next = cnt_inc;
                            from_sync_next = (mode_reg == MODE_SYNC);
                            mode_next      = MODE_FRAME;
                            sum_next       = '0;
                            count_next     = '0;
                        end
                        else if (cnt_inc >= MAX_C)
                        begin
                            // overlong frame is dropped
                            mode_next  = MODE_HUNT;
                            sum_next   = '0;
                            count_next = '0;
                        end
                        else
                        begin
                            sum_next   = sum_add;
                            count_next = cnt_inc;
                        end
                    end
                end
                default:
                begin
                    mode_next  = MODE_HUNT;
                    sum_next   = '0;
                    count_next = '0;
                end
            endcase
        end
    end

    // readout sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load && rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // readout sequencer outputs
    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        load        = (state_reg == ST_LOAD) && (!out_valid_reg || m_tready);
        mem_re      = (state_reg == ST_READ) || (load && !rd_last);
        mem_raddr   = (state_reg == ST_READ) ? rd_idx_reg : rd_idx_reg + AW'(1);
        rd_idx_next = rd_idx_reg;
        if (state_reg == ST_IDLE)
        begin
            rd_idx_next = '0;
        end
        else if (load && !rd_last)
        begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HUNT;
            sum_reg       <= '0;
            count_reg     <= '0;
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_len_reg <= frame_len_next;
        from_sync_reg <= from_sync_next;
        if (load)
        begin
            out_byte_reg <= mem_rdata;
            out_pos_reg  <= pos_ext[POS_W-1:0];
            out_last_reg <= rd_last;
            out_sync_reg <= from_sync_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - BYTE_W - POS_W){1'b0}}, out_pos_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_sync_reg;

`ifndef SYNTHESIS
    a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HUNT |-> count_reg == '0 && sum_reg == '0)
        else $error("hunting with stale sum or count");

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> CW'(rd_idx_reg) < frame_len_reg)
        else $error("readout index beyond frame length");

    a_read_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |=> state_reg == ST_LOAD)
        else $error("buffer read not followed by load");

    a_last_ends_readout: assert property (@(posedge clk) disable iff (!rst_n)
        load && rd_last |=> state_reg == ST_IDLE && m_tvalid && m_tlast)
        else $error("last byte loaded but readout not finished");

    a_done_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> state_reg == ST_IDLE)
        else $error("frame completed during readout");
`endif

endmodule

`default_nettype wire

FILE: rtl/checksum_delimited_frame_sync_top.sv
// checksum-delimited frame sync
// input: s_tvalid/s_tready/s_tdata, one received byte per transaction
// output: m_tvalid/m_tready/m_tdata/m_tlast/m_tuser, one message byte per
//   transaction; m_tlast marks the checksum byte, m_tuser is set on every
//   byte of the frame found while hunting for the sync id
// cfg_we/cfg_wdata write the sync message id (reset value 128)
// bytes are dropped until one equals the sync id; then bytes are stored in
// the frame buffer memory with a running sum until a byte makes the sum
// wrap to zero, and the whole frame is replayed from the buffer
// a byte that does not complete a frame leaves s_tready high, so the next
// byte can be taken on the next cycle
// a completing byte starts a readout: a registered buffer read (ST_READ), then
// one byte per cycle into the output register (ST_LOAD) while the receiver
// is not stalling; the input is blocked for the whole readout
// a stalled receiver holds the output register; the readout waits and no
// input is taken until the last byte is in the output register
// after reset the block hunts with empty sum and count; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module checksum_delimited_frame_sync_top
    import csfs_pkg::*;
#(
    parameter int MAX_MSG_LEN = MAX_MSG_LEN_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [BYTE_W-1:0]    cfg_wdata,   // sync_mid
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,     // [7:0] rx_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,     // [7:0] msg_byte, [12:8] byte_pos
    output logic                      m_tlast,
    output logic                      m_tuser      // from_sync
);

    localparam int AW = $clog2(MAX_MSG_LEN);
    localparam int CW = $clog2(MAX_MSG_LEN + 1);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;

    csfs_ctrl #(
        .MAX_MSG_LEN (MAX_MSG_LEN),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    csfs_buf #(
        .DEPTH (MAX_MSG_LEN),
        .AW    (AW)
    ) u_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire
